@@ rtl/core/msrs_pkg.sv @@
// Shared types and constants of the magnetometer SPI read sequencer.
package msrs_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned OutDataW  = 72;

  localparam logic [CfgIdxW-1:0] CFG_WAIT_TICKS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PERIOD_CODE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPIKE_LIMIT  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEALTH_LIMIT = 2'd3;

  localparam logic [15:0] WAIT_TICKS_RST   = 16'd79;
  localparam logic [2:0]  PERIOD_CODE_RST  = 3'd3;
  localparam logic [14:0] SPIKE_LIMIT_RST  = 15'd500;
  localparam logic [7:0]  HEALTH_LIMIT_RST = 8'd20;

  localparam logic [7:0]  DUMMY_BYTE = 8'h00;

  localparam logic        ACT_TICK = 1'b0;
  localparam logic        ACT_SPI  = 1'b1;

  localparam logic [1:0]  AX_NONE = 2'd0;
  localparam logic [1:0]  AX_X    = 2'd1;
  localparam logic [1:0]  AX_Y    = 2'd2;
  localparam logic [1:0]  AX_Z    = 2'd3;

  typedef enum logic [4:0] {
    PH_RESET = 5'b00001,
    PH_START = 5'b00010,
    PH_WAIT  = 5'b00100,
    PH_BYTE1 = 5'b01000,
    PH_BYTE2 = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [15:0] wait_ticks;
    logic [2:0]  period_code;
    logic [14:0] spike_limit;
    logic [7:0]  health_limit;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  // last field in the lowest bits
  typedef struct packed {
    logic [3:0]         pad;
    logic [7:0]         health_count;
    logic signed [15:0] z_value;
    logic signed [15:0] y_value;
    logic signed [15:0] x_value;
    logic               sample_stored;
    logic [7:0]         send_byte;
    logic               send_valid;
    logic               reset_active;
    logic               select_active;
  } result_t;

endpackage

@@ rtl/core/msrs_cfg_regs.sv @@
// Configuration register file of the read sequencer.
module msrs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [msrs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [msrs_pkg::CfgDataW-1:0] cfg_data,
  output msrs_pkg::cfg_t                cfg
);

  msrs_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_ticks   <= msrs_pkg::WAIT_TICKS_RST;
      cfg_r.period_code  <= msrs_pkg::PERIOD_CODE_RST;
      cfg_r.spike_limit  <= msrs_pkg::SPIKE_LIMIT_RST;
      cfg_r.health_limit <= msrs_pkg::HEALTH_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        msrs_pkg::CFG_WAIT_TICKS:   cfg_r.wait_ticks   <= cfg_data;
        msrs_pkg::CFG_PERIOD_CODE:  cfg_r.period_code  <= cfg_data[2:0];
        msrs_pkg::CFG_SPIKE_LIMIT:  cfg_r.spike_limit  <= cfg_data[14:0];
        msrs_pkg::CFG_HEALTH_LIMIT: cfg_r.health_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/msrs_in_stage.sv @@
// Input register stage holding one accepted word.
module msrs_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  msrs_pkg::item_t in_item,
  output logic            item_valid,
  output msrs_pkg::item_t item,
  input  logic            item_take
);

  logic            valid_r;
  msrs_pkg::item_t item_r;

  assign in_tready  = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ rtl/core/msrs_seq_core.sv @@
// Sequencer state, step logic and result register.
module msrs_seq_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msrs_pkg::cfg_t                cfg,
  input  logic                          item_valid,
  input  msrs_pkg::item_t               item,
  output logic                          item_take,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [msrs_pkg::OutDataW-1:0] out_tdata
);

  msrs_pkg::phase_t  phase_r, phase_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic [15:0]       wait_r, wait_nxt;
  logic [7:0]        high_r, high_nxt;
  logic [15:0]       x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [7:0]        health_r, health_nxt;
  logic              out_valid_r;
  msrs_pkg::result_t res_r, res_nxt;

  logic              send_valid, stored;
  logic [7:0]        send_byte;
  logic [15:0]       word;
  logic [15:0]       mag;
  logic              differ;

  assign item_take  = item_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  assign word = {high_r, item.rx_byte};
  assign mag  = word[15] ? (~word + 16'd1) : word;

  always_comb begin
    phase_nxt  = phase_r;
    axis_nxt   = axis_r;
    wait_nxt   = wait_r;
    high_nxt   = high_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    health_nxt = health_r;
    send_valid = 1'b0;
    send_byte  = msrs_pkg::DUMMY_BYTE;
    stored     = 1'b0;
    differ     = 1'b0;
    if (item.action == msrs_pkg::ACT_TICK) begin
      unique case (phase_r)
        msrs_pkg::PH_RESET: phase_nxt = msrs_pkg::PH_START;
        msrs_pkg::PH_START: begin
          if (axis_r != msrs_pkg::AX_NONE) begin
            send_valid = 1'b1;
            send_byte  = {1'b0, cfg.period_code, 2'b00, axis_r};
            wait_nxt   = cfg.wait_ticks;
            phase_nxt  = msrs_pkg::PH_WAIT;
          end else begin
            axis_nxt  = msrs_pkg::AX_X;
            phase_nxt = msrs_pkg::PH_RESET;
          end
        end
        msrs_pkg::PH_WAIT: begin
          if (wait_r == 16'd0) begin
            send_valid = 1'b1;
            phase_nxt  = msrs_pkg::PH_BYTE1;
          end else begin
            wait_nxt = wait_r - 16'd1;
          end
        end
        msrs_pkg::PH_BYTE1, msrs_pkg::PH_BYTE2: ;
        default: phase_nxt = msrs_pkg::PH_RESET;
      endcase
    end else begin
      unique case (phase_r)
        msrs_pkg::PH_BYTE1: begin
          high_nxt   = item.rx_byte;
          send_valid = 1'b1;
          phase_nxt  = msrs_pkg::PH_BYTE2;
        end
        msrs_pkg::PH_BYTE2: begin
          if (mag < {1'b0, cfg.spike_limit}) begin
            stored = 1'b1;
            unique case (axis_r)
              msrs_pkg::AX_X: begin
                x_nxt    = word;
                axis_nxt = msrs_pkg::AX_Y;
              end
              msrs_pkg::AX_Y: begin
                y_nxt    = word;
                axis_nxt = msrs_pkg::AX_Z;
              end
              msrs_pkg::AX_Z: begin
                z_nxt    = word;
                axis_nxt = msrs_pkg::AX_X;
              end
              default: begin
                stored   = 1'b0;
                axis_nxt = msrs_pkg::AX_X;
              end
            endcase
          end
          phase_nxt = msrs_pkg::PH_RESET;
          differ    = (x_nxt != y_nxt) || (x_nxt != z_nxt) || (y_nxt != z_nxt);
          if (differ) begin
            if (health_r < cfg.health_limit) begin
              health_nxt = health_r + 8'd1;
            end
          end else if (health_r != 8'd0) begin
            health_nxt = health_r - 8'd1;
          end
        end
        msrs_pkg::PH_RESET, msrs_pkg::PH_START, msrs_pkg::PH_WAIT: ;
        default: phase_nxt = msrs_pkg::PH_RESET;
      endcase
    end

    res_nxt.pad           = 4'd0;
    res_nxt.select_active = (phase_nxt != msrs_pkg::PH_RESET);
    res_nxt.reset_active  = (phase_nxt == msrs_pkg::PH_START);
    res_nxt.send_valid    = send_valid;
    res_nxt.send_byte     = send_byte;
    res_nxt.sample_stored = stored;
    res_nxt.x_value       = x_nxt;
    res_nxt.y_value       = y_nxt;
    res_nxt.z_value       = z_nxt;
    res_nxt.health_count  = health_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= msrs_pkg::PH_RESET;
      axis_r      <= msrs_pkg::AX_X;
      wait_r      <= 16'd0;
      high_r      <= 8'd0;
      x_r         <= 16'd0;
      y_r         <= 16'd0;
      z_r         <= 16'd0;
      health_r    <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        phase_r  <= phase_nxt;
        axis_r   <= axis_nxt;
        wait_r   <= wait_nxt;
        high_r   <= high_nxt;
        x_r      <= x_nxt;
        y_r      <= y_nxt;
        z_r      <= z_nxt;
        health_r <= health_nxt;
      end
      if (item_take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ rtl/core/magnetometer_spi_read_sequencer_top.sv @@
// Top level of the magnetometer SPI read sequencer.
//
// Usage: each input word is one event. in_tuser is the event kind (0 = timer
// tick, 1 = SPI byte done) and in_tdata the received SPI byte. Each event
// yields exactly one output word on the out_ channel holding the line levels,
// the byte transfer to start (if any), the stored-sample flag, the last
// accepted x, y and z readings and the health counter.
// The cfg_ channel writes one setting per word (index 0 wait ticks, 1 period
// code, 2 spike limit, 3 health limit); cfg_ready is always high. Write
// settings only while no event is in flight.
// An accepted word passes the input register, then the result register.
// Throughput: one word per cycle while the receiver takes results, set by the
// single step stage that updates the sequencer state.
// When the receiver stalls, the result register holds its word and one more
// word waits in the input register; further input is held off by in_tready.
// Reset (rst_n low, synchronous) restores the default settings, releases the
// sensor select, selects the x axis, clears stored samples and health, and
// empties both registers.
module magnetometer_spi_read_sequencer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  input  logic                          in_tuser,   // [0] action
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] select_active, [1] reset_active, [2] send_valid, [10:3] send_byte,
  // [11] sample_stored, [27:12] x_value, [43:28] y_value, [59:44] z_value,
  // [67:60] health_count, [71:68] zero
  output logic [msrs_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [msrs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [msrs_pkg::CfgDataW-1:0] cfg_data
);

  msrs_pkg::cfg_t  cfg;
  msrs_pkg::item_t in_item;
  msrs_pkg::item_t item;
  logic            item_valid;
  logic            item_take;

  assign in_item.action  = in_tuser;
  assign in_item.rx_byte = in_tdata;

  msrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msrs_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  msrs_seq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
